// ===== rtl/rhsm_pkg.sv =====
package rhsm_pkg;

  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;

  localparam int BYTE_W        = 8;
  localparam int HASH_W        = 16;
  localparam int LEN_W         = 5;
  localparam int PAT_BYTES     = 16;
  localparam int PAT_IDX_W     = 4;
  localparam int MATCH_START_W = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOD    = 3'd4;

  localparam logic [LEN_W-1:0]  RST_LEN  = 5'd1;
  localparam logic [HASH_W-1:0] RST_BASE = 16'd101;
  localparam logic [HASH_W-1:0] RST_MOD  = 16'd29;
  localparam logic [HASH_W-1:0] MOD_MIN  = 16'd2;

  // Modular multiply-add unit: (a * b + c) mod p, reduced DIG_W bits per step
  localparam int MM_A_W      = HASH_W + 1;
  localparam int RED_W       = 36;
  localparam int DIG_W       = 4;
  localparam int RED_STEPS   = RED_W / DIG_W;
  localparam int STEP_CNT_W  = $clog2(RED_STEPS + 1);

  typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_bytes_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic              start;
    logic [MM_A_W-1:0] a;
    logic [HASH_W-1:0] b;
    logic [BYTE_W-1:0] c;
  } mm_req_t;

endpackage

// ===== rtl/rolling_hash_string_match_core.sv =====
// Channel  | Ports                                              | Dir | Handshake
// ---------+----------------------------------------------------+-----+-------------
// input    | in_text_byte, in_end_of_text                       | in  | in_valid/in_ready
// result   | out_match_found, out_match_start, out_hash_hit     | out | out_valid/out_ready
// config   | cfg_index, cfg_wdata                               | in  | cfg_we
//
// From acceptance to the result register: two passes through the modular
// multiply-add unit (multiply, nine 4-bit remainder steps), a setup state
// and the result load; in_ready stays low until the result is loaded.
// Synchronous active-low reset; after it and after every known register
// write the weight and pattern hash are derived again, in_ready low.
// A result held by out_ready stalls the next one in ST_EMIT, in_ready low.
module rolling_hash_string_match_core #(
  parameter int MAX_PATTERN   = rhsm_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = rhsm_pkg::POSITION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [rhsm_pkg::BYTE_W-1:0]           in_text_byte,
  input  logic                                  in_end_of_text,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_match_found,
  output logic [rhsm_pkg::MATCH_START_W-1:0]    out_match_start,
  output logic                                  out_hash_hit,
  input  logic                                  cfg_we,
  input  logic [rhsm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rhsm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DLW    = 9'b000000010,
    ST_DLW_W  = 9'b000000100,
    ST_DPH    = 9'b000001000,
    ST_DPH_W  = 9'b000010000,
    ST_SUB_W  = 9'b000100000,
    ST_ROLL   = 9'b001000000,
    ST_ROLL_W = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [rhsm_pkg::CFG_DATA_W-1:0] pat_lo_r, pat_hi_r;
  logic [rhsm_pkg::LEN_W-1:0]      len_r;
  logic [rhsm_pkg::HASH_W-1:0]     base_r, mod_r;

  // Derived and text state
  logic [rhsm_pkg::HASH_W-1:0]     lw_r, ph_r, rh_r;
  logic [rhsm_pkg::LEN_W-1:0]      cnt_r;
  logic [POSITION_BITS-1:0]        bytes_seen_r;

  // Per-transaction payload
  logic [rhsm_pkg::BYTE_W-1:0]        byte_r;
  logic                               last_r;
  logic [rhsm_pkg::MM_A_W-1:0]        diff_r;
  logic                               hit_r, found_r;
  logic [rhsm_pkg::MATCH_START_W-1:0] start_r;

  // Result register
  logic                               out_valid_r;
  logic                               out_found_r, out_hit_r;
  logic [rhsm_pkg::MATCH_START_W-1:0] out_start_r;

  logic [rhsm_pkg::LEN_W-1:0]   len_eff, len_m1;
  logic [rhsm_pkg::HASH_W-1:0]  modulus;
  logic [POSITION_BITS-1:0]     len_m1_pos;
  rhsm_pkg::pat_bytes_t         pattern;
  logic                         accept, emit_fire, cfg_known, derive_go, full, hit_now;
  logic [rhsm_pkg::BYTE_W-1:0]  win [MAX_PATTERN];
  logic [rhsm_pkg::BYTE_W-1:0]  outgoing;
  logic [MAX_PATTERN-1:0]       eq_vec;
  rhsm_pkg::cell_ctl_t          cell_ctl;
  rhsm_pkg::mm_req_t            mm_req;
  logic [rhsm_pkg::HASH_W-1:0]  mm_res;
  logic                         mm_done;

  // Clamp length into 1..MAX_PATTERN and modulus to at least two.
  always_comb begin
    if (len_r == '0) begin
      len_eff = rhsm_pkg::LEN_W'(1);
    end else if (len_r > rhsm_pkg::LEN_W'(MAX_PATTERN)) begin
      len_eff = rhsm_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_r;
    end
  end

  assign len_m1     = len_eff - rhsm_pkg::LEN_W'(1);
  assign len_m1_pos = {{(POSITION_BITS - rhsm_pkg::LEN_W){1'b0}}, len_m1};
  assign modulus    = (mod_r < rhsm_pkg::MOD_MIN) ? rhsm_pkg::MOD_MIN : mod_r;
  assign pattern    = {pat_hi_r, pat_lo_r};

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign cfg_known = cfg_index inside {[rhsm_pkg::REG_PAT_LO:rhsm_pkg::REG_MOD]};
  assign derive_go = cfg_we && cfg_known;

  // Byte leaving the hash window, sampled before the shift.
  assign outgoing = win[len_m1[WIN_IDX_W-1:0]];

  assign full    = (bytes_seen_r >= len_m1_pos);
  assign hit_now = full && (mm_res == ph_r);

  // Window chain: advance on acceptance, drop everything after end of text.
  assign cell_ctl.shift = accept;
  assign cell_ctl.clear = emit_fire && last_r;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [rhsm_pkg::BYTE_W-1:0] din;
    if (k == 0) begin : g_head
      assign din = in_text_byte;
    end else begin : g_body
      assign din = win[k-1];
    end
    rhsm_cell #(
      .IDX(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (cell_ctl),
      .din    (din),
      .pattern(pattern),
      .len    (len_eff),
      .dout   (win[k]),
      .eq     (eq_vec[k])
    );
  end

  rhsm_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mm_req),
    .modulus(modulus),
    .result (mm_res),
    .done   (mm_done)
  );

  // Requests to the modular unit and sequencing.
  always_comb begin
    state_nxt    = state_r;
    mm_req.start = 1'b0;
    mm_req.a     = '0;
    mm_req.b     = base_r;
    mm_req.c     = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Weight of the outgoing byte: outgoing * leading_weight mod p
          mm_req.start = 1'b1;
          mm_req.a     = rhsm_pkg::MM_A_W'(outgoing);
          mm_req.b     = lw_r;
          state_nxt    = ST_SUB_W;
        end
      end
      ST_DLW: begin
        if (cnt_r == len_m1) begin
          state_nxt = ST_DPH;
        end else begin
          mm_req.start = 1'b1;
          mm_req.a     = rhsm_pkg::MM_A_W'(lw_r);
          state_nxt    = ST_DLW_W;
        end
      end
      ST_DLW_W: begin
        if (mm_done) begin
          state_nxt = ST_DLW;
        end
      end
      ST_DPH: begin
        if (cnt_r == len_eff) begin
          state_nxt = ST_IDLE;
        end else begin
          mm_req.start = 1'b1;
          mm_req.a     = rhsm_pkg::MM_A_W'(ph_r);
          mm_req.c     = pattern[cnt_r[rhsm_pkg::PAT_IDX_W-1:0]];
          state_nxt    = ST_DPH_W;
        end
      end
      ST_DPH_W: begin
        if (mm_done) begin
          state_nxt = ST_DPH;
        end
      end
      ST_SUB_W: begin
        if (mm_done) begin
          state_nxt = ST_ROLL;
        end
      end
      ST_ROLL: begin
        // New hash: (running - sub) * base + byte, all mod p
        mm_req.start = 1'b1;
        mm_req.a     = diff_r;
        mm_req.c     = byte_r;
        state_nxt    = ST_ROLL_W;
      end
      ST_ROLL_W: begin
        if (mm_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Any known register write restarts the derivation.
    if (derive_go) begin
      state_nxt = ST_DLW;
    end
  end

  // Control state, configuration and hash state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_DLW;
      pat_lo_r     <= '0;
      pat_hi_r     <= '0;
      len_r        <= rhsm_pkg::RST_LEN;
      base_r       <= rhsm_pkg::RST_BASE;
      mod_r        <= rhsm_pkg::RST_MOD;
      lw_r         <= rhsm_pkg::HASH_W'(1);
      ph_r         <= '0;
      cnt_r        <= '0;
      rh_r         <= '0;
      bytes_seen_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          rhsm_pkg::REG_PAT_LO: pat_lo_r <= cfg_wdata;
          rhsm_pkg::REG_PAT_HI: pat_hi_r <= cfg_wdata;
          rhsm_pkg::REG_LEN:    len_r    <= cfg_wdata[rhsm_pkg::LEN_W-1:0];
          rhsm_pkg::REG_BASE:   base_r   <= cfg_wdata[rhsm_pkg::HASH_W-1:0];
          rhsm_pkg::REG_MOD:    mod_r    <= cfg_wdata[rhsm_pkg::HASH_W-1:0];
          default: begin
          end
        endcase
      end

      // Derivation: leading weight first, then the pattern hash. A known
      // register write starts it over from the top.
      if (derive_go) begin
        lw_r  <= rhsm_pkg::HASH_W'(1);
        ph_r  <= '0;
        cnt_r <= '0;
      end else begin
        if (state_r == ST_DLW && cnt_r == len_m1) begin
          cnt_r <= '0;
        end
        if (state_r == ST_DLW_W && mm_done) begin
          lw_r  <= mm_res;
          cnt_r <= cnt_r + rhsm_pkg::LEN_W'(1);
        end
        if (state_r == ST_DPH_W && mm_done) begin
          ph_r  <= mm_res;
          cnt_r <= cnt_r + rhsm_pkg::LEN_W'(1);
        end
      end

      if (state_r == ST_ROLL_W && mm_done) begin
        rh_r <= mm_res;
      end

      if (emit_fire) begin
        if (last_r) begin
          rh_r         <= '0;
          bytes_seen_r <= '0;
        end else if (bytes_seen_r != '1) begin
          bytes_seen_r <= bytes_seen_r + POSITION_BITS'(1);
        end
      end

      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Transaction payload and result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_text_byte;
      last_r <= in_end_of_text;
    end
    if (state_r == ST_SUB_W && mm_done) begin
      diff_r <= rhsm_pkg::MM_A_W'(rh_r) + rhsm_pkg::MM_A_W'(modulus)
                - rhsm_pkg::MM_A_W'(mm_res);
    end
    if (state_r == ST_ROLL_W && mm_done) begin
      hit_r   <= hit_now;
      found_r <= hit_now && (&eq_vec);
      start_r <= (hit_now && (&eq_vec))
                 ? rhsm_pkg::MATCH_START_W'(bytes_seen_r - len_m1_pos) : '0;
    end
    if (emit_fire) begin
      out_found_r <= found_r;
      out_hit_r   <= hit_r;
      out_start_r <= start_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_found = out_found_r;
  assign out_match_start = out_start_r;
  assign out_hash_hit    = out_hit_r;

endmodule

// ===== rtl/rhsm_cell.sv =====
// One window byte: shifts from its neighbor and checks itself against the
// pattern byte that lines up with its place in the window.
module rhsm_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rhsm_pkg::cell_ctl_t              ctl,
  input  logic [rhsm_pkg::BYTE_W-1:0]      din,
  input  rhsm_pkg::pat_bytes_t             pattern,
  input  logic [rhsm_pkg::LEN_W-1:0]       len,
  output logic [rhsm_pkg::BYTE_W-1:0]      dout,
  output logic                             eq
);

  logic [rhsm_pkg::BYTE_W-1:0]    data_r;
  logic [rhsm_pkg::PAT_IDX_W-1:0] pidx;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      data_r <= '0;
    end else if (ctl.shift) begin
      data_r <= din;
    end
  end

  assign pidx = rhsm_pkg::PAT_IDX_W'(len - rhsm_pkg::LEN_W'(IDX) - rhsm_pkg::LEN_W'(1));
  assign eq   = (len <= rhsm_pkg::LEN_W'(IDX)) || (data_r == pattern[pidx]);
  assign dout = data_r;

endmodule

// ===== rtl/rhsm_modmul.sv =====
// Iterative (a * b + c) mod p: one multiply, then DIG_W remainder bits a cycle.
module rhsm_modmul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rhsm_pkg::mm_req_t             req,
  input  logic [rhsm_pkg::HASH_W-1:0]   modulus,
  output logic [rhsm_pkg::HASH_W-1:0]   result,
  output logic                          done
);

  logic [rhsm_pkg::MM_A_W+rhsm_pkg::HASH_W-1:0] prod;
  logic [rhsm_pkg::RED_W-1:0]                   acc_r;
  logic [rhsm_pkg::HASH_W-1:0]                  r_r;
  logic [rhsm_pkg::HASH_W-1:0]                  r_nxt;
  logic [rhsm_pkg::STEP_CNT_W-1:0]              cnt_r;
  logic                                         busy_r;
  logic                                         done_r;

  assign prod = req.a * req.b;

  always_comb begin
    logic [rhsm_pkg::HASH_W:0] rem;
    rem = {1'b0, r_r};
    for (int i = 0; i < rhsm_pkg::DIG_W; i++) begin
      rem = {rem[rhsm_pkg::HASH_W-1:0], acc_r[rhsm_pkg::RED_W-1-i]};
      if (rem >= {1'b0, modulus}) begin
        rem = rem - {1'b0, modulus};
      end
    end
    r_nxt = rem[rhsm_pkg::HASH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= rhsm_pkg::STEP_CNT_W'(rhsm_pkg::RED_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - rhsm_pkg::STEP_CNT_W'(1);
        if (cnt_r == rhsm_pkg::STEP_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= rhsm_pkg::RED_W'(prod) + rhsm_pkg::RED_W'(req.c);
      r_r   <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r << rhsm_pkg::DIG_W;
      r_r   <= r_nxt;
    end
  end

  assign result = r_r;
  assign done   = done_r;

endmodule

// ===== sim/text_match_checker.sv =====
`timescale 1ns / 1ps

module text_match_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [rhsm_pkg::BYTE_W-1:0]         in_text_byte,
  input  logic                                in_end_of_text,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_match_found,
  input  logic [rhsm_pkg::MATCH_START_W-1:0]  out_match_start,
  input  logic                                out_hash_hit,
  input  logic                                cfg_we,
  input  logic [rhsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rhsm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int unsigned                         mismatch_count,
  output int unsigned                         pending_count
);
  import rhsm_pkg::*;

  typedef struct packed {
    logic                     found;
    logic [MATCH_START_W-1:0] start;
    logic                     hit;
  } match_report_t;

  localparam logic [POSITION_BITS_DEF-1:0] POS_LIMIT = '1;

  logic [CFG_DATA_W-1:0]        pat_lo, pat_hi;
  logic [LEN_W-1:0]             pat_len_reg;
  logic [HASH_W-1:0]            base_reg, mod_reg;
  logic [BYTE_W-1:0]            window [PAT_BYTES];
  logic [HASH_W-1:0]            rolling_sum, pattern_sum, lead_weight;
  logic [POSITION_BITS_DEF-1:0] text_pos;
  match_report_t                expected_reports [$];
  int unsigned                  fault_tally;
  int unsigned                  report_index;

  function automatic int unsigned active_len();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
    return int'(pat_len_reg);
  endfunction

  function automatic longint unsigned active_mod();
    return (mod_reg < MOD_MIN) ? MOD_MIN : mod_reg;
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_byte(int unsigned j);
    pat_bytes_t pb;
    pb = {pat_hi, pat_lo};
    return pb[j];
  endfunction

  // Recompute the pattern hash and base^(len-1) after any register change.
  function automatic void refresh_pattern_hash();
    longint unsigned p, b, w, h;
    int unsigned     n;
    n = active_len();
    p = active_mod();
    b = base_reg % p;
    w = 1 % p;
    for (int unsigned i = 1; i < n; i++) w = (w * b) % p;
    h = 0;
    for (int unsigned i = 0; i < n; i++) h = (h * b + pattern_byte(i)) % p;
    lead_weight = w[HASH_W-1:0];
    pattern_sum = h[HASH_W-1:0];
  endfunction

  function automatic void clear_text();
    for (int i = 0; i < PAT_BYTES; i++) window[i] = '0;
    rolling_sum = '0;
    text_pos    = '0;
  endfunction

  // Roll one text byte into the window and work out the report it causes.
  function automatic match_report_t advance_window(logic [BYTE_W-1:0] b_in, logic eot);
    match_report_t   r;
    int unsigned     n;
    longint unsigned p, b, idx, drop, h;
    logic            same;
    n    = active_len();
    p    = active_mod();
    b    = base_reg % p;
    idx  = text_pos;
    drop = (64'(window[n-1]) * 64'(lead_weight)) % p;
    h    = 64'(rolling_sum) % p;
    h    = (((h + p - drop) % p) * b + 64'(b_in)) % p;
    rolling_sum = h[HASH_W-1:0];
    for (int i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = b_in;
    r = '0;
    if (idx >= n - 1) begin
      r.hit = (h == 64'(pattern_sum));
      if (r.hit) begin
        same = 1'b1;
        for (int unsigned i = 0; i < n; i++)
          if (window[n-1-i] != pattern_byte(i)) same = 1'b0;
        r.found = same;
        if (same) r.start = MATCH_START_W'(idx - (n - 1));
      end
    end
    if (text_pos != POS_LIMIT) text_pos++;
    if (eot) clear_text();
    return r;
  endfunction

  always @(posedge clk) begin : watch_edge
    match_report_t got, want, next_rep;
    if (!rst_n) begin
      pat_lo      = '0;
      pat_hi      = '0;
      pat_len_reg = RST_LEN;
      base_reg    = RST_BASE;
      mod_reg     = RST_MOD;
      clear_text();
      refresh_pattern_hash();
      expected_reports.delete();
      fault_tally  = 0;
      report_index = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAT_LO: pat_lo      = cfg_wdata;
          REG_PAT_HI: pat_hi      = cfg_wdata;
          REG_LEN:    pat_len_reg = cfg_wdata[LEN_W-1:0];
          REG_BASE:   base_reg    = cfg_wdata[HASH_W-1:0];
          REG_MOD:    mod_reg     = cfg_wdata[HASH_W-1:0];
          default:    ;
        endcase
        refresh_pattern_hash();
      end
      if (out_valid && out_ready) begin
        got.found = out_match_found;
        got.start = out_match_start;
        got.hit   = out_hash_hit;
        if (expected_reports.size() == 0) begin
          fault_tally++;
          if (fault_tally <= 10)
            $display("%0t: result %0d unexpected (found %0b start %0d hit %0b)",
                     $realtime, report_index, got.found, got.start, got.hit);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            fault_tally++;
            if (fault_tally <= 10)
              $display("%0t: result %0d: found %0b/%0b start %0d/%0d hit %0b/%0b (exp/act)",
                       $realtime, report_index, want.found, got.found,
                       want.start, got.start, want.hit, got.hit);
          end
        end
        report_index++;
      end
      if (in_valid && in_ready) begin
        next_rep = advance_window(in_text_byte, in_end_of_text);
        expected_reports.insert(expected_reports.size(), next_rep);
      end
    end
    mismatch_count <= fault_tally;
    pending_count  <= expected_reports.size();
  end

endmodule

// ===== sim/rolling_hash_string_match_core_test.sv =====
`timescale 1ns / 1ps

module rolling_hash_string_match_core_test;
  import rhsm_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [BYTE_W-1:0]        in_text_byte;
  logic                     in_end_of_text;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_match_found;
  logic [MATCH_START_W-1:0] out_match_start;
  logic                     out_hash_hit;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;

  int unsigned mismatches;
  int unsigned pending;

  // Knobs shared between the sender and the receiver processes.
  bit          quiet_tail;     // last part of the run: no idling on either side
  bit          hold_request;   // ask the receiver for one long hold-off
  int unsigned gap_odds;       // sender idles before roughly one in gap_odds items; 0 = never
  pat_bytes_t  cur_pattern;    // pattern as last written, used to plant matches
  int unsigned cur_len;        // pattern length as the block will use it
  int unsigned bytes_sent;

  rolling_hash_string_match_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_found (out_match_found),
    .out_match_start (out_match_start),
    .out_hash_hit    (out_hash_hit),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  text_match_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_found (out_match_found),
    .out_match_start (out_match_start),
    .out_hash_hit    (out_hash_hit),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatches),
    .pending_count   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("rolling_hash_string_match_core regression: fail");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request, and a
  // steady ready in the quiet tail. Exactly one assignment per loop pass, so
  // out_ready never gets two updates in the same time step.
  initial begin
    forever begin
      if (quiet_tail) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (hold_request) begin
        // hold off long enough that the block backs up and drops in_ready
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Offer one text byte and hold it until the block takes the transaction.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
    if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Stop offering and hold until every outstanding result has been taken.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write all five registers back to back. Junk above the field width must
  // be dropped by the block.
  task automatic write_settings(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [LEN_W-1:0] len,
                                input logic [HASH_W-1:0] base,
                                input logic [HASH_W-1:0] modulus);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) junk = '0;
    cfg_we    <= 1'b1;
    cfg_index <= REG_PAT_LO;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_PAT_HI;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= REG_LEN;
    cfg_wdata <= {junk[63:LEN_W], len};
    @(posedge clk);
    cfg_index <= REG_BASE;
    cfg_wdata <= {junk[63:HASH_W], base};
    @(posedge clk);
    cfg_index <= REG_MOD;
    cfg_wdata <= {junk[63:HASH_W], modulus};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_pattern = {hi, lo};
    cur_len = (len == 0) ? 1 : ((len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len);
  endtask

  // Send a text of n bytes. Mostly pattern bytes and planted copies of the
  // whole pattern, so hash hits and real matches are common; stray end
  // markers and copies cut short by the text end act as broken sequences.
  task automatic send_text(input int unsigned n, input bit close_text);
    int unsigned k;
    logic [BYTE_W-1:0] b;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int unsigned j = 0; j < cur_len && k < n; j++) begin
          send_byte(cur_pattern[j], close_text && k == n - 1);
          k++;
        end
      end else begin
        b = $urandom_range(0, 1) ? cur_pattern[$urandom_range(0, cur_len - 1)]
                                 : BYTE_W'($urandom);
        send_byte(b, (close_text && k == n - 1) || $urandom_range(0, 47) == 0);
        k++;
      end
    end
  endtask

  // Pick the settings of a random phase. Lengths and moduli cycle through their
  // extremes at an offset, bases on another period, so the combinations vary.
  task automatic random_settings(input int unsigned phase);
    logic [63:0]       lo, hi;
    logic [LEN_W-1:0]  len;
    logic [HASH_W-1:0] base, modulus;
    logic [BYTE_W-1:0] sym_a, sym_b;
    pat_bytes_t        pat;
    case (phase % 6)
      0:       len = 5'd16;
      1:       len = 5'd31;
      2:       len = 5'd0;
      3:       len = 5'd1;
      4:       len = LEN_W'($urandom_range(2, 8));
      default: len = LEN_W'($urandom_range(0, 31));
    endcase
    case ((phase + 2) % 6)
      0:       modulus = 16'hFFFF;
      1:       modulus = 16'd0;
      2:       modulus = 16'd1;
      3:       modulus = MOD_MIN;
      4:       modulus = HASH_W'($urandom_range(2, 40));
      default: modulus = HASH_W'($urandom);
    endcase
    case (phase % 4)
      0:       base = 16'hFFFF;
      1:       base = 16'd0;
      2:       base = 16'd1;
      default: base = HASH_W'($urandom);
    endcase
    // two-symbol patterns give plenty of near misses and overlapping matches
    sym_a = BYTE_W'($urandom);
    sym_b = ~sym_a;
    for (int i = 0; i < PAT_BYTES; i++)
      pat[i] = $urandom_range(0, 1) ? sym_a : sym_b;
    if (phase % 2 == 1) pat = {$urandom, $urandom, $urandom, $urandom};
    {hi, lo} = pat;
    write_settings(lo, hi, len, base, modulus);
  endtask

  initial begin
    quiet_tail     = 1'b0;
    hold_request   = 1'b0;
    gap_odds       = 4;
    bytes_sent     = 0;
    cur_pattern    = '0;
    cur_len        = 1;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_text_byte   <= '0;
    in_end_of_text <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_PAT_LO;
    cfg_wdata      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one-byte pattern 0x00, base 101, modulus 29. The very
    // first window matches, 0x1D collides on the hash without matching, and
    // the end marker restarts the position count.
    send_byte(8'h00, 1'b0);
    send_byte(8'h1D, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    wait_drain();

    // Change settings mid-text: "abcd" with base 256, modulus 101. Two
    // matches, neither at the text start; leave the text open.
    write_settings(64'h0000_0000_6463_6261, 64'h0, 5'd4, 16'd256, 16'd101);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(8'h64, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(8'h64, 1'b0);
    wait_drain();

    // Length zero acts as one, modulus zero as two, base zero kills the roll.
    write_settings(64'h0, 64'hFFFF_FFFF_FFFF_FF00, 5'd0, 16'd0, 16'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drain();

    // Random phases of about 65 bytes each, drained and reconfigured between
    // them. Texts left open at a phase end see the next settings mid-text.
    for (int unsigned phase = 0; phase < 10; phase++) begin
      random_settings(phase);
      if (phase == 9) quiet_tail = 1'b1;
      if (phase == 2) hold_request = 1'b1;
      while (bytes_sent < 16 + 65 * (phase + 1)) begin
        case ($urandom_range(0, 2))
          0:       gap_odds = 0;
          1:       gap_odds = 3;
          default: gap_odds = 8;
        endcase
        send_text($urandom_range(1, 40), $urandom_range(0, 4) != 0);
      end
      wait_drain();
    end

    // Let any stray late result show up before the verdict.
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("rolling_hash_string_match_core regression: pass");
    end else begin
      $display("rolling_hash_string_match_core regression: fail");
    end
    $finish;
  end

endmodule
